// File: rtl/core/spi_pkg.sv
package spi_pkg;

    // Default coordinate width and quotient fraction bits
    localparam int COORD_WIDTH_DEF = 16;
    localparam int T_FRAC_BITS_DEF = 16;

    // Entries in the queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 4;

endpackage

// File: rtl/core/spi_front.sv
module spi_front
    import spi_pkg::*;
#(
    parameter int W = COORD_WIDTH_DEF,
    parameter int T = T_FRAC_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [3*W-1:0]      seg_begin,
    input  logic [3*W-1:0]      seg_end,
    input  logic [3*W-1:0]      vertex_a,
    input  logic [3*W-1:0]      vertex_b,
    input  logic [3*W-1:0]      vertex_c,
    output logic                push_valid,
    input  logic                push_ready,
    output logic                push_hit,
    output logic [T:0]          push_tq,
    output logic [3*(W+1)-1:0]  push_d,
    output logic [3*W-1:0]      push_b
);

    localparam int DW = W + 1;        // coordinate differences
    localparam int NW = 2 * W + 3;    // normal components
    localparam int PW = NW + DW;      // dot product terms
    localparam int SW = PW + 2;       // dot product sums
    localparam int RW = SW + 1;       // divider remainder
    localparam int L  = 6 + T;        // pipeline depth

    logic [L-1:0] vld_reg;
    logic         adv;

    // Stage registers
    logic signed [DW-1:0] u1_reg [3];
    logic signed [DW-1:0] v1_reg [3];
    logic signed [DW-1:0] d1_reg [3];
    logic signed [DW-1:0] w1_reg [3];
    logic signed [W-1:0]  b1_reg [3];

    logic signed [2*DW-1:0] pa2_reg [3];
    logic signed [2*DW-1:0] pb2_reg [3];
    logic signed [DW-1:0]   d2_reg [3];
    logic signed [DW-1:0]   w2_reg [3];
    logic signed [W-1:0]    b2_reg [3];

    logic signed [NW-1:0] n3_reg [3];
    logic signed [DW-1:0] d3_reg [3];
    logic signed [DW-1:0] w3_reg [3];
    logic signed [W-1:0]  b3_reg [3];

    logic signed [PW-1:0] pd4_reg [3];
    logic signed [PW-1:0] pw4_reg [3];
    logic signed [DW-1:0] d4_reg [3];
    logic signed [W-1:0]  b4_reg [3];

    logic signed [SW-1:0] den5_reg;
    logic signed [SW-1:0] num5_reg;
    logic signed [DW-1:0] d5_reg [3];
    logic signed [W-1:0]  b5_reg [3];

    // Divider stages, index 0 is the classify stage
    logic [RW-1:0]      rem_reg [T+1];
    logic [T-1:0]       quo_reg [T+1];
    logic [SW-1:0]      dm_reg [T+1];
    logic               hit_reg [T+1];
    logic               eq_reg [T+1];
    logic [3*DW-1:0]    d_reg [T+1];
    logic [3*W-1:0]     b_reg [T+1];

    // Advance the whole pipeline unless the last beat is blocked
    assign adv       = !vld_reg[L-1] || push_ready;
    assign req_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[L-2:0], req_valid};
        end
    end

    genvar i;
    generate
        for (i = 0; i < 3; i++)
        begin : g_axis
            localparam int J = (i + 1) % 3;
            localparam int K = (i + 2) % 3;
            logic signed [W-1:0] cb;
            logic signed [W-1:0] ce;
            logic signed [W-1:0] ca;
            logic signed [W-1:0] cv1;
            logic signed [W-1:0] cv2;

            assign cb  = seg_begin[i*W +: W];
            assign ce  = seg_end[i*W +: W];
            assign ca  = vertex_a[i*W +: W];
            assign cv1 = vertex_b[i*W +: W];
            assign cv2 = vertex_c[i*W +: W];

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    // edges, direction and offset
                    u1_reg[i] <= DW'(cv1) - DW'(ca);
                    v1_reg[i] <= DW'(cv2) - DW'(ca);
                    d1_reg[i] <= DW'(ce) - DW'(cb);
                    w1_reg[i] <= DW'(ca) - DW'(cb);
                    b1_reg[i] <= cb;
                    // cross product terms
                    pa2_reg[i] <= u1_reg[J] * v1_reg[K];
                    pb2_reg[i] <= u1_reg[K] * v1_reg[J];
                    d2_reg[i]  <= d1_reg[i];
                    w2_reg[i]  <= w1_reg[i];
                    b2_reg[i]  <= b1_reg[i];
                    // normal
                    n3_reg[i] <= NW'(pa2_reg[i]) - NW'(pb2_reg[i]);
                    d3_reg[i] <= d2_reg[i];
                    w3_reg[i] <= w2_reg[i];
                    b3_reg[i] <= b2_reg[i];
                    // dot product terms
                    pd4_reg[i] <= n3_reg[i] * PW'(d3_reg[i]);
                    pw4_reg[i] <= n3_reg[i] * PW'(w3_reg[i]);
                    d4_reg[i]  <= d3_reg[i];
                    b4_reg[i]  <= b3_reg[i];
                    d5_reg[i]  <= d4_reg[i];
                    b5_reg[i]  <= b4_reg[i];
                end
            end
        end
    endgenerate

    // Sum the dot products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den5_reg <= SW'(pd4_reg[0]) + SW'(pd4_reg[1]) + SW'(pd4_reg[2]);
            num5_reg <= SW'(pw4_reg[0]) + SW'(pw4_reg[1]) + SW'(pw4_reg[2]);
        end
    end

    // Classify: sign and magnitude test
    logic [SW-1:0] dm_c;
    logic [SW-1:0] nm_c;
    logic          hit_c;

    always_comb
    begin
        dm_c  = den5_reg[SW-1] ? SW'(-den5_reg) : SW'(den5_reg);
        nm_c  = num5_reg[SW-1] ? SW'(-num5_reg) : SW'(num5_reg);
        hit_c = (den5_reg != '0)
             && !((num5_reg != '0) && (num5_reg[SW-1] != den5_reg[SW-1]))
             && (nm_c <= dm_c);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= RW'(nm_c);
            quo_reg[0] <= '0;
            dm_reg[0]  <= dm_c;
            hit_reg[0] <= hit_c;
            eq_reg[0]  <= (nm_c == dm_c);
            d_reg[0]   <= {d5_reg[2], d5_reg[1], d5_reg[0]};
            b_reg[0]   <= {b5_reg[2], b5_reg[1], b5_reg[0]};
        end
    end

    // Restoring divider, one quotient bit per stage
    genvar k;
    generate
        for (k = 0; k < T; k++)
        begin : g_div
            logic [RW-1:0] sh;
            logic          ge;

            assign sh = {rem_reg[k][RW-2:0], 1'b0};
            assign ge = sh >= {1'b0, dm_reg[k]};

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[k+1] <= ge ? (sh - {1'b0, dm_reg[k]}) : sh;
                    quo_reg[k+1] <= {quo_reg[k][T-2:0], ge};
                    dm_reg[k+1]  <= dm_reg[k];
                    hit_reg[k+1] <= hit_reg[k];
                    eq_reg[k+1]  <= eq_reg[k];
                    d_reg[k+1]   <= d_reg[k];
                    b_reg[k+1]   <= b_reg[k];
                end
            end
        end
    endgenerate

    // Hand the finished beat to the queue
    assign push_valid = vld_reg[L-1];
    assign push_hit   = hit_reg[T];
    assign push_tq    = eq_reg[T] ? {1'b1, {T{1'b0}}} : {1'b0, quo_reg[T]};
    assign push_d     = d_reg[T];
    assign push_b     = b_reg[T];

endmodule

// File: rtl/core/spi_queue.sv
module spi_queue
    import spi_pkg::*;
#(
    parameter int DATA_W = 8,
    parameter int DEPTH  = QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    localparam int AW = $clog2(DEPTH);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [AW-1:0]     wr_reg;
    logic [AW-1:0]     rd_reg;
    logic [AW:0]       cnt_reg;
    logic              push;
    logic              pop;

    assign push_ready = cnt_reg != (AW+1)'(DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_reg];

    // Store the incoming beat
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/spi_back.sv
module spi_back
    import spi_pkg::*;
#(
    parameter int W = COORD_WIDTH_DEF,
    parameter int T = T_FRAC_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  logic                pop_hit,
    input  logic [T:0]          pop_tq,
    input  logic [3*(W+1)-1:0]  pop_d,
    input  logic [3*W-1:0]      pop_b,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic                hit,
    output logic [W-1:0]        point_x,
    output logic [W-1:0]        point_y,
    output logic [W-1:0]        point_z
);

    localparam int DW = W + 1;
    localparam int MW = DW + T + 2;
    localparam int SW = W + 2;
    localparam logic signed [SW-1:0] SMAX = SW'((64'd1 << (W - 1)) - 64'd1);
    localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);

    logic                bv_reg;
    logic                bh_reg;
    logic signed [MW-1:0] p_reg [3];
    logic signed [W-1:0]  b_reg [3];
    logic                ov_reg;
    logic                oh_reg;
    logic [W-1:0]        pt_reg [3];
    logic                adv;

    assign adv       = !ov_reg || !rsp_stall;
    assign pop_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            bv_reg <= pop_valid;
            ov_reg <= bv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bh_reg <= pop_hit;
            oh_reg <= bh_reg;
        end
    end

    genvar i;
    generate
        for (i = 0; i < 3; i++)
        begin : g_axis
            logic signed [DW-1:0] dc;
            logic signed [MW-1:0] q;
            logic signed [SW-1:0] s;
            logic [W-1:0]         sat;

            assign dc = pop_d[i*DW +: DW];

            // Floor the scaled step, add to begin, clamp
            always_comb
            begin
                q = p_reg[i] >>> T;
                s = SW'(b_reg[i]) + SW'(q);
                if (s > SMAX)
                begin
                    sat = W'(SMAX);
                end
                else if (s < SMIN)
                begin
                    sat = W'(SMIN);
                end
                else
                begin
                    sat = W'(s);
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    p_reg[i]  <= MW'(dc) * $signed({1'b0, pop_tq});
                    b_reg[i]  <= pop_b[i*W +: W];
                    pt_reg[i] <= bh_reg ? sat : '0;
                end
            end
        end
    endgenerate

    assign rsp_valid = ov_reg;
    assign hit       = oh_reg;
    assign point_x   = pt_reg[0];
    assign point_y   = pt_reg[1];
    assign point_z   = pt_reg[2];

endmodule

// File: rtl/core/segment_plane_intersect.sv
// Segment versus triangle-plane intersection, fully pipelined.
// Throughput: one item per cycle unless rsp_stall holds the output;
// the divider has one stage per quotient bit.
// A four-entry queue parts geometry/divide from the point stage and output.
// Reset (rst_n low, asynchronous) empties pipeline and queue; no payload is cleared.
module segment_plane_intersect
    import spi_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  logic [3*COORD_WIDTH-1:0] seg_begin,
    input  logic [3*COORD_WIDTH-1:0] seg_end,
    input  logic [3*COORD_WIDTH-1:0] vertex_a,
    input  logic [3*COORD_WIDTH-1:0] vertex_b,
    input  logic [3*COORD_WIDTH-1:0] vertex_c,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output logic                     hit,
    output logic [COORD_WIDTH-1:0]   point_x,
    output logic [COORD_WIDTH-1:0]   point_y,
    output logic [COORD_WIDTH-1:0]   point_z
);

    localparam int W  = COORD_WIDTH;
    localparam int T  = T_FRAC_BITS;
    localparam int DW = W + 1;
    localparam int QW = 1 + (T + 1) + 3 * DW + 3 * W;

    logic              f_valid;
    logic              f_ready;
    logic              f_hit;
    logic [T:0]        f_tq;
    logic [3*DW-1:0]   f_d;
    logic [3*W-1:0]    f_b;
    logic              q_valid;
    logic              q_ready;
    logic [QW-1:0]     q_data;

    spi_front #(.W(W), .T(T)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .seg_begin  (seg_begin),
        .seg_end    (seg_end),
        .vertex_a   (vertex_a),
        .vertex_b   (vertex_b),
        .vertex_c   (vertex_c),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_hit   (f_hit),
        .push_tq    (f_tq),
        .push_d     (f_d),
        .push_b     (f_b)
    );

    spi_queue #(.DATA_W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  ({f_hit, f_tq, f_d, f_b}),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    spi_back #(.W(W), .T(T)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .pop_hit   (q_data[QW-1]),
        .pop_tq    (q_data[QW-2 -: T+1]),
        .pop_d     (q_data[3*W +: 3*DW]),
        .pop_b     (q_data[3*W-1:0]),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .hit       (hit),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z)
    );

endmodule

// File: rtl/core/spi_checker.sv
module spi_checker
    import spi_pkg::*;
#(
    parameter int W = COORD_WIDTH_DEF
)
(
    input logic         clk,
    input logic         rst_n,
    input logic         req_stall,
    input logic         rsp_valid,
    input logic         rsp_stall,
    input logic         hit,
    input logic [W-1:0] point_x,
    input logic [W-1:0] point_y,
    input logic [W-1:0] point_z
);

    // Hold a stalled result beat
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result beat dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(hit) && $stable(point_x)
            && $stable(point_y) && $stable(point_z))
        else $error("stalled result beat changed");

    // A miss carries a zero point
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !hit |-> point_x == '0 && point_y == '0 && point_z == '0)
        else $error("miss with nonzero point");

    // Input backpressure only comes from a blocked output
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid)
        else $error("input stalled with no pending result");

endmodule

bind segment_plane_intersect spi_checker #(.W(COORD_WIDTH)) u_spi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .hit       (hit),
    .point_x   (point_x),
    .point_y   (point_y),
    .point_z   (point_z)
);
